@@ hdl/fds_pkg.sv @@
// ----------------------------------------------------------------------------
// fds_pkg
// Shared types and constants for the frame delta smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package fds_pkg;

	localparam int WINDOW_SAMPLES = 16;

	localparam int DELTA_W  = 20;
	localparam int SCALE_W  = 16;
	localparam int SCALED_W = 28;
	localparam int PROD_W   = DELTA_W + SCALE_W;
	localparam int FRAC_W   = 8;
	localparam int TOTAL_W  = 48;
	localparam int FRAME_W  = 32;

	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_B = 2;

	localparam logic REG_TIME_SCALE = 1'b0;
	localparam logic REG_MAX_DELTA  = 1'b1;

	localparam logic [SCALE_W-1:0] TIME_SCALE_RST = SCALE_W'(256);
	localparam logic [DELTA_W-1:0] MAX_DELTA_RST  = DELTA_W'(100000);
	localparam logic [DELTA_W-1:0] MAX_DELTA_MIN  = DELTA_W'(1000);

	localparam logic MODE_UPDATE = 1'b0;
	localparam logic MODE_CLEAR  = 1'b1;

	typedef struct packed {
		logic [SCALE_W-1:0] time_scale;
		logic [DELTA_W-1:0] max_delta_us;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_UPD,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

@@ hdl/fds_if.sv @@
// ----------------------------------------------------------------------------
// fds_if
// Valid/ready channels for update transactions and result transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface fds_in_if;
	logic                        valid;
	logic                        ready;
	logic                        mode;
	logic [fds_pkg::DELTA_W-1:0] delta_us;

	modport source (output valid, mode, delta_us, input ready);
	modport sink (input valid, mode, delta_us, output ready);
endinterface

interface fds_out_if;
	logic                         valid;
	logic                         ready;
	logic [fds_pkg::DELTA_W-1:0]  clamped_delta;
	logic [fds_pkg::SCALED_W-1:0] scaled_delta;
	logic [fds_pkg::TOTAL_W-1:0]  unscaled_total;
	logic [fds_pkg::TOTAL_W-1:0]  scaled_total;
	logic [fds_pkg::SCALED_W-1:0] smooth_delta;
	logic [fds_pkg::FRAME_W-1:0]  frame_total;

	modport source (output valid, clamped_delta, scaled_delta, unscaled_total,
		scaled_total, smooth_delta, frame_total, input ready);
	modport sink (input valid, clamped_delta, scaled_delta, unscaled_total,
		scaled_total, smooth_delta, frame_total, output ready);
endinterface

`default_nettype wire

@@ hdl/frame_delta_smoother.sv @@
// An update transaction runs 16 multiply steps, one ring update, then SUM_W
//   quotient bits from the serial divider; the divider is skipped when the window
//   holds no nonzero sample. A clear skips multiply and divide and goes straight
//   to the done state.
// Throughput: one transaction at a time; the next is taken once the result
//   sits in the output register. Reset clears control state, totals and ring valid bits.
// ----------------------------------------------------------------------------
// frame_delta_smoother
// Clamps and scales frame deltas, keeps running totals and a windowed average.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_delta_smoother #(
	parameter int WINDOW_SAMPLES = fds_pkg::WINDOW_SAMPLES
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [fds_pkg::PADDR_W-1:0] paddr,
	input  wire logic [fds_pkg::PDATA_W-1:0] pwdata,
	output logic      [fds_pkg::PDATA_W-1:0] prdata,
	output logic                             pready,
	fds_in_if.sink                           upd,
	fds_out_if.source                        res
);

	localparam int POS_W = $clog2(WINDOW_SAMPLES);
	localparam int CNT_W = $clog2(WINDOW_SAMPLES + 1);
	localparam int SUM_W = fds_pkg::SCALED_W + POS_W;

	fds_pkg::cfg_t  cfg;
	fds_pkg::state_t state_q, state_nxt;

	logic upd_acc, out_free;
	logic mul_start, div_start, ring_we, out_load;
	logic mul_busy, div_busy;
	logic [fds_pkg::PROD_W-1:0] product;
	logic [SUM_W-1:0]           quotient;

	logic [fds_pkg::DELTA_W-1:0]  clamp_in;
	logic [fds_pkg::DELTA_W-1:0]  clamped_q;
	logic [fds_pkg::SCALED_W-1:0] scaled_q, smooth_q, scaled;
	logic [fds_pkg::TOTAL_W-1:0]  uacc_q, sacc_q;
	logic [fds_pkg::FRAME_W-1:0]  frame_q;
	logic [POS_W-1:0]             pos_q;
	logic [SUM_W-1:0]             sum_q, sum_nxt;
	logic [CNT_W-1:0]             cnt_q, cnt_nxt;

	logic [fds_pkg::SCALED_W-1:0] ring_mem [WINDOW_SAMPLES];
	logic [fds_pkg::SCALED_W-1:0] ring_rd_q, old_val;
	logic [WINDOW_SAMPLES-1:0]    ring_vld_q;

	logic                         res_valid_q;
	logic [fds_pkg::DELTA_W-1:0]  res_clamped_q;
	logic [fds_pkg::SCALED_W-1:0] res_scaled_q, res_smooth_q;
	logic [fds_pkg::TOTAL_W-1:0]  res_utot_q, res_stot_q;
	logic [fds_pkg::FRAME_W-1:0]  res_frame_q;

	fds_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign clamp_in = (upd.delta_us < cfg.max_delta_us) ? upd.delta_us : cfg.max_delta_us;

	fds_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (clamp_in),
		.mplier  (cfg.time_scale),
		.busy    (mul_busy),
		.product (product)
	);

	fds_div #(
		.DVD_W (SUM_W),
		.DVS_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_nxt),
		.divisor  (cnt_nxt),
		.busy     (div_busy),
		.quotient (quotient)
	);

	assign upd_acc  = upd.valid & upd.ready;
	assign out_free = !res_valid_q || res.ready;
	assign scaled   = product[fds_pkg::FRAC_W +: fds_pkg::SCALED_W];
	assign old_val  = ring_vld_q[pos_q] ? ring_rd_q : '0;
	assign sum_nxt  = sum_q - SUM_W'(old_val) + SUM_W'(scaled);
	assign cnt_nxt  = cnt_q - CNT_W'(old_val != '0) + CNT_W'(scaled != '0);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			fds_pkg::ST_IDLE: begin
				if (upd_acc) begin
					state_nxt = (upd.mode == fds_pkg::MODE_CLEAR) ?
						fds_pkg::ST_DONE : fds_pkg::ST_MUL;
				end
			end
			fds_pkg::ST_MUL: begin
				if (!mul_busy) state_nxt = fds_pkg::ST_UPD;
			end
			fds_pkg::ST_UPD: begin
				state_nxt = (cnt_nxt == '0) ? fds_pkg::ST_DONE : fds_pkg::ST_DIV;
			end
			fds_pkg::ST_DIV: begin
				if (!div_busy) state_nxt = fds_pkg::ST_DONE;
			end
			fds_pkg::ST_DONE: begin
				if (out_free) state_nxt = fds_pkg::ST_IDLE;
			end
			default: state_nxt = fds_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		upd.ready = 1'b0;
		mul_start = 1'b0;
		div_start = 1'b0;
		ring_we   = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			fds_pkg::ST_IDLE: begin
				upd.ready = 1'b1;
				mul_start = upd.valid && (upd.mode == fds_pkg::MODE_UPDATE);
			end
			fds_pkg::ST_UPD: begin
				ring_we   = 1'b1;
				div_start = (cnt_nxt != '0);
			end
			fds_pkg::ST_DONE: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= fds_pkg::ST_IDLE;
			pos_q      <= '0;
			sum_q      <= '0;
			cnt_q      <= '0;
			uacc_q     <= '0;
			sacc_q     <= '0;
			frame_q    <= '0;
			ring_vld_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (upd_acc && upd.mode == fds_pkg::MODE_CLEAR) begin
				pos_q      <= '0;
				sum_q      <= '0;
				cnt_q      <= '0;
				uacc_q     <= '0;
				sacc_q     <= '0;
				frame_q    <= '0;
				ring_vld_q <= '0;
			end else if (ring_we) begin
				pos_q             <= (pos_q == POS_W'(WINDOW_SAMPLES - 1)) ? '0 : pos_q + 1'b1;
				sum_q             <= sum_nxt;
				cnt_q             <= cnt_nxt;
				uacc_q            <= uacc_q + fds_pkg::TOTAL_W'(clamped_q);
				sacc_q            <= sacc_q + fds_pkg::TOTAL_W'(scaled);
				frame_q           <= frame_q + 1'b1;
				ring_vld_q[pos_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[pos_q] <= scaled;
		end
		ring_rd_q <= ring_mem[pos_q];
	end

	always_ff @(posedge clk) begin
		if (upd_acc) begin
			clamped_q <= (upd.mode == fds_pkg::MODE_CLEAR) ? '0 : clamp_in;
			scaled_q  <= '0;
			smooth_q  <= '0;
		end else if (ring_we) begin
			scaled_q <= scaled;
			smooth_q <= scaled;
		end else if (state_q == fds_pkg::ST_DIV && !div_busy) begin
			smooth_q <= quotient[fds_pkg::SCALED_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_clamped_q <= clamped_q;
			res_scaled_q  <= scaled_q;
			res_utot_q    <= uacc_q;
			res_stot_q    <= sacc_q;
			res_smooth_q  <= smooth_q;
			res_frame_q   <= frame_q;
		end
	end

	assign res.valid          = res_valid_q;
	assign res.clamped_delta  = res_clamped_q;
	assign res.scaled_delta   = res_scaled_q;
	assign res.unscaled_total = res_utot_q;
	assign res.scaled_total   = res_stot_q;
	assign res.smooth_delta   = res_smooth_q;
	assign res.frame_total    = res_frame_q;

endmodule

`default_nettype wire

@@ hdl/fds_apb.sv @@
// ----------------------------------------------------------------------------
// fds_apb
// APB register file: time scale and delta clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module fds_apb (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [fds_pkg::PADDR_W-1:0] paddr,
	input  wire logic [fds_pkg::PDATA_W-1:0] pwdata,
	output logic      [fds_pkg::PDATA_W-1:0] prdata,
	output logic                             pready,
	output fds_pkg::cfg_t                    cfg
);

	fds_pkg::cfg_t               cfg_q;
	logic                        wr_en;
	logic [fds_pkg::DELTA_W-1:0] wr_max;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign wr_max = pwdata[fds_pkg::DELTA_W-1:0];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.time_scale   <= fds_pkg::TIME_SCALE_RST;
			cfg_q.max_delta_us <= fds_pkg::MAX_DELTA_RST;
		end else if (wr_en) begin
			unique case (paddr[fds_pkg::REG_IDX_B])
				fds_pkg::REG_TIME_SCALE: begin
					cfg_q.time_scale <= pwdata[fds_pkg::SCALE_W-1:0];
				end
				fds_pkg::REG_MAX_DELTA: begin
					cfg_q.max_delta_us <= (wr_max < fds_pkg::MAX_DELTA_MIN) ?
						fds_pkg::MAX_DELTA_MIN : wr_max;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[fds_pkg::REG_IDX_B])
			fds_pkg::REG_TIME_SCALE: prdata = fds_pkg::PDATA_W'(cfg_q.time_scale);
			fds_pkg::REG_MAX_DELTA:  prdata = fds_pkg::PDATA_W'(cfg_q.max_delta_us);
			default:                 prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

@@ hdl/fds_mul.sv @@
// ----------------------------------------------------------------------------
// fds_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fds_mul (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [fds_pkg::DELTA_W-1:0] mcand,
	input  wire logic [fds_pkg::SCALE_W-1:0] mplier,
	output logic                             busy,
	output logic      [fds_pkg::PROD_W-1:0]  product
);

	localparam int CNT_W = $clog2(fds_pkg::SCALE_W + 1);

	logic [fds_pkg::DELTA_W-1:0] m_q;
	logic [fds_pkg::DELTA_W:0]   hi_q;
	logic [fds_pkg::SCALE_W-1:0] lo_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        busy_q;
	logic [fds_pkg::DELTA_W:0]   hi_sum;

	assign hi_sum  = lo_q[0] ? (hi_q + (fds_pkg::DELTA_W + 1)'(m_q)) : hi_q;
	assign busy    = busy_q;
	assign product = {hi_q[fds_pkg::DELTA_W-1:0], lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(fds_pkg::SCALE_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			m_q  <= mcand;
			hi_q <= '0;
			lo_q <= mplier;
		end else if (busy_q) begin
			{hi_q, lo_q} <= {1'b0, hi_sum, lo_q[fds_pkg::SCALE_W-1:1]};
		end
	end

endmodule

`default_nettype wire

@@ hdl/fds_div.sv @@
// ----------------------------------------------------------------------------
// fds_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fds_div #(
	parameter int DVD_W = 32,
	parameter int DVS_W = 5
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output logic                  busy,
	output logic      [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DVS_W:0]   shifted;
	logic             ge;
	logic [DVS_W:0]   diff;

	assign shifted  = {rem_q, quo_q[DVD_W-1]};
	assign ge       = shifted >= {1'b0, dvs_q};
	assign diff     = shifted - {1'b0, dvs_q};
	assign busy     = busy_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

endmodule

`default_nettype wire
